FILE: src/lrdc32_pkg.sv
// ----------------------------------------------------------------------------
// lrdc32_pkg: shared types and constants for the log record deframer
// Word layouts of the byte and result channels, kind and status codes, and
// the bytewise CRC-32 update used on the record body.
// ----------------------------------------------------------------------------
package lrdc32_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] MAX_LEN_RESET   = 32'd67108864;
  localparam logic [7:0]        SET_OP_RESET    = 8'd0;
  localparam logic [7:0]        DELETE_OP_RESET = 8'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_OP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE_OP = 2'd2;

  // Record layout.
  localparam int unsigned CRC_BYTES  = 4;
  localparam int unsigned TERM_END   = 8;
  localparam int unsigned INDEX_END  = 16;
  localparam int unsigned OP_POS     = 16;
  localparam int unsigned HDR_BYTES  = 21;
  localparam int unsigned VLEN_BYTES = 4;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

  // Byte kinds.
  localparam logic [2:0] KIND_CRC  = 3'd0;
  localparam logic [2:0] KIND_HDR  = 3'd1;
  localparam logic [2:0] KIND_KEY  = 3'd2;
  localparam logic [2:0] KIND_VLEN = 3'd3;
  localparam logic [2:0] KIND_VAL  = 3'd4;
  localparam logic [2:0] KIND_NONE = 3'd5;

  // Status codes.
  localparam logic [3:0] ST_BUSY      = 4'd0;
  localparam logic [3:0] ST_OK        = 4'd1;
  localparam logic [3:0] ST_END       = 4'd2;
  localparam logic [3:0] ST_KEY_LEN   = 4'd3;
  localparam logic [3:0] ST_VAL_LEN   = 4'd4;
  localparam logic [3:0] ST_CRC       = 4'd5;
  localparam logic [3:0] ST_BAD_OP    = 4'd6;
  localparam logic [3:0] ST_EMPTY_KEY = 4'd7;
  localparam logic [3:0] ST_SET_EMPTY = 4'd8;
  localparam logic [3:0] ST_HALTED    = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  byte_out;
    logic        record_done;
    logic [3:0]  status;
    logic [63:0] term;
    logic [63:0] log_index;
    logic [7:0]  op_code;
    logic [31:0] key_length;
    logic [31:0] value_length;
  } out_word_t;

  // Reflected CRC-32, one byte per call.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Verdict at the end of a record, checks in priority order.
  function automatic logic [3:0] verdict(input logic [31:0] crc,
                                         input logic [31:0] expected,
                                         input logic [7:0]  op,
                                         input logic [31:0] key_len,
                                         input logic [31:0] val_len,
                                         input logic [7:0]  set_op,
                                         input logic [7:0]  delete_op);
    logic [3:0] st;
    if ((crc ^ CRC_PRESET) != expected) begin
      st = ST_CRC;
    end else if (op != set_op && op != delete_op) begin
      st = ST_BAD_OP;
    end else if (key_len == 32'd0) begin
      st = ST_EMPTY_KEY;
    end else if (op == set_op && val_len == 32'd0) begin
      st = ST_SET_EMPTY;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

FILE: src/lrdc32_if.sv
// ----------------------------------------------------------------------------
// lrdc32_if: valid/ready channels of the log record deframer
// One interface for the incoming byte words and one for the result words.
// ----------------------------------------------------------------------------
interface lrdc32_in_if;
  import lrdc32_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrdc32_out_if;
  import lrdc32_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/log_record_deframer_crc32_core.sv
// ----------------------------------------------------------------------------
// log_record_deframer_crc32_core: big-endian log record parser with CRC-32
// Tags every stream byte, assembles the record header and checks the body
// CRC, lengths and op code, giving one result word per input word.
// ----------------------------------------------------------------------------
// The block takes one byte word per clock and returns exactly one result
// word for it in the next cycle; a new word is accepted in every cycle as
// long as the result register is empty or being read in the same cycle. The
// rate is set by the single stage between acceptance and the result register,
// which holds the bytewise CRC-32 update and the 32-bit length compare.
// The term, index, op and length fields on each result show the header
// registers after that byte, so they carry the record under assembly until
// the next record overwrites them. After a corrupt verdict every byte is
// dropped with status halted until a word with end_of_input set arrives.
module log_record_deframer_crc32_core (
  input  logic                                clk,
  input  logic                                rst_n,
  lrdc32_in_if.sink                           in_ch,
  lrdc32_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [lrdc32_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrdc32_pkg::DATA_W-1:0]       cfg_data
);
  import lrdc32_pkg::*;

  typedef enum logic [2:0] {
    PH_CRC  = 3'd0,
    PH_HDR  = 3'd1,
    PH_KEY  = 3'd2,
    PH_VLEN = 3'd3,
    PH_VAL  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] exp_crc_r, exp_crc_nxt;
  logic [63:0] term_r, term_nxt;
  logic [63:0] index_r, index_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [31:0] klen_r, klen_nxt;
  logic [31:0] vlen_r, vlen_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        halted_r, halted_nxt;

  logic [31:0] max_len_r;
  logic [7:0]  set_op_r;
  logic [7:0]  delete_op_r;

  logic        out_valid_r;
  out_word_t   out_data_r, out_data_nxt;

  logic        in_acc;
  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [32:0] cnt_inc;
  logic [2:0]  kind;
  logic [7:0]  bout;
  logic [3:0]  status;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign b       = in_ch.data.data_byte;
  assign crc_upd = crc_byte(crc_r, b);
  assign cnt_inc = {1'b0, cnt_r} + 33'd1;

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    exp_crc_nxt = exp_crc_r;
    term_nxt    = term_r;
    index_nxt   = index_r;
    op_nxt      = op_r;
    klen_nxt    = klen_r;
    vlen_nxt    = vlen_r;
    crc_nxt     = crc_r;
    halted_nxt  = halted_r;
    kind        = KIND_NONE;
    bout        = 8'd0;
    status      = ST_BUSY;

    if (in_ch.data.end_of_input) begin
      phase_nxt  = PH_CRC;
      cnt_nxt    = 32'd0;
      crc_nxt    = CRC_PRESET;
      halted_nxt = 1'b0;
      status     = ST_END;
    end else if (halted_r) begin
      status = ST_HALTED;
    end else begin
      bout    = b;
      cnt_nxt = cnt_inc[31:0];
      unique case (phase_r)
        PH_HDR: begin
          kind    = KIND_HDR;
          crc_nxt = crc_upd;
          if (cnt_r < 32'(TERM_END)) begin
            term_nxt = {term_r[55:0], b};
          end else if (cnt_r < 32'(INDEX_END)) begin
            index_nxt = {index_r[55:0], b};
          end else if (cnt_r == 32'(OP_POS)) begin
            op_nxt = b;
          end else begin
            klen_nxt = {klen_r[23:0], b};
          end
          if (cnt_inc >= 33'(HDR_BYTES)) begin
            cnt_nxt = 32'd0;
            if (klen_nxt > max_len_r) begin
              status = ST_KEY_LEN;
            end else begin
              phase_nxt = (klen_nxt != 32'd0) ? PH_KEY : PH_VLEN;
            end
          end
        end
        PH_KEY: begin
          kind    = KIND_KEY;
          crc_nxt = crc_upd;
          if (cnt_inc >= {1'b0, klen_r}) begin
            cnt_nxt   = 32'd0;
            phase_nxt = PH_VLEN;
          end
        end
        PH_VLEN: begin
          kind     = KIND_VLEN;
          crc_nxt  = crc_upd;
          vlen_nxt = {vlen_r[23:0], b};
          if (cnt_inc >= 33'(VLEN_BYTES)) begin
            cnt_nxt = 32'd0;
            if (vlen_nxt > max_len_r) begin
              status = ST_VAL_LEN;
            end else if (vlen_nxt == 32'd0) begin
              status = verdict(crc_upd, exp_crc_r, op_r, klen_r, vlen_nxt,
                               set_op_r, delete_op_r);
            end else begin
              phase_nxt = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          kind    = KIND_VAL;
          crc_nxt = crc_upd;
          if (cnt_inc >= {1'b0, vlen_r}) begin
            cnt_nxt = 32'd0;
            status  = verdict(crc_upd, exp_crc_r, op_r, klen_r, vlen_r,
                              set_op_r, delete_op_r);
          end
        end
        default: begin
          kind        = KIND_CRC;
          exp_crc_nxt = {exp_crc_r[23:0], b};
          if (cnt_inc >= 33'(CRC_BYTES)) begin
            cnt_nxt   = 32'd0;
            phase_nxt = PH_HDR;
          end
        end
      endcase

      // Any finished record, good or corrupt, restarts the parser.
      if (status >= ST_KEY_LEN) begin
        halted_nxt = 1'b1;
      end
      if (status != ST_BUSY) begin
        phase_nxt = PH_CRC;
        cnt_nxt   = 32'd0;
        crc_nxt   = CRC_PRESET;
      end
    end

    out_data_nxt.byte_kind    = kind;
    out_data_nxt.byte_out     = bout;
    out_data_nxt.record_done  = (status == ST_OK);
    out_data_nxt.status       = status;
    out_data_nxt.term         = term_nxt;
    out_data_nxt.log_index    = index_nxt;
    out_data_nxt.op_code      = op_nxt;
    out_data_nxt.key_length   = klen_nxt;
    out_data_nxt.value_length = vlen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CRC;
      cnt_r       <= 32'd0;
      exp_crc_r   <= 32'd0;
      term_r      <= 64'd0;
      index_r     <= 64'd0;
      op_r        <= 8'd0;
      klen_r      <= 32'd0;
      vlen_r      <= 32'd0;
      crc_r       <= CRC_PRESET;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        exp_crc_r <= exp_crc_nxt;
        term_r    <= term_nxt;
        index_r   <= index_nxt;
        op_r      <= op_nxt;
        klen_r    <= klen_nxt;
        vlen_r    <= vlen_nxt;
        crc_r     <= crc_nxt;
        halted_r  <= halted_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r   <= MAX_LEN_RESET;
      set_op_r    <= SET_OP_RESET;
      delete_op_r <= DELETE_OP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LEN:   max_len_r   <= cfg_data;
        CFG_SET_OP:    set_op_r    <= cfg_data[7:0];
        CFG_DELETE_OP: delete_op_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (phase_r == PH_CRC && cnt_r == 32'd0 && crc_r == CRC_PRESET))
    else $error("halted parser is not parked at record start");

  a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.data.end_of_input) |=> (!halted_r && phase_r == PH_CRC))
    else $error("end of input did not clear halt and restart the parser");

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.record_done == (out_data_r.status == ST_OK)))
    else $error("record_done disagrees with status");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.byte_kind == KIND_NONE) |->
      (out_data_r.byte_out == 8'd0 &&
       (out_data_r.status == ST_END || out_data_r.status == ST_HALTED)))
    else $error("dropped byte shown with data or wrong status");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: log record deframer with CRC-32 check
// Streams framed log records into the deframer, some intact and some
// damaged, truncated or cut by end of input, and compares every result
// word with a cycle-free prediction of the parser, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import lrdc32_pkg::*;

  typedef enum logic [2:0] {AT_CRC, AT_HEADER, AT_KEY, AT_VALUE_LEN, AT_VALUE} rec_phase_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int FIELD_CAP     = 12;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_WORDS  = 360;
  localparam int RANDOM_PHASES = 6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  lrdc32_in_if  byte_ch ();
  lrdc32_out_if result_ch ();

  log_record_deframer_crc32_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Register mirrors and parser state of the prediction.
  logic [31:0] len_limit;
  logic [7:0]  set_code;
  logic [7:0]  delete_code;
  rec_phase_t  rec_phase;
  logic [31:0] rec_count;
  logic [31:0] rec_crc_field;
  logic [63:0] rec_term;
  logic [63:0] rec_index;
  logic [7:0]  rec_op;
  logic [31:0] rec_key_len;
  logic [31:0] rec_val_len;
  logic [31:0] body_crc;
  logic        rec_halted;

  out_word_t  expected_results[$];
  logic [7:0] frame_bytes[$];

  int          error_count = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_step = 4'd0;

  function automatic logic [31:0] crc32_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    return r;
  endfunction

  function void restart_record();
    rec_phase = AT_CRC;
    rec_count = 32'd0;
    body_crc  = CRC_PRESET;
  endfunction

  function void reset_model();
    len_limit     = MAX_LEN_RESET;
    set_code      = SET_OP_RESET;
    delete_code   = DELETE_OP_RESET;
    rec_crc_field = 32'd0;
    rec_term      = 64'd0;
    rec_index     = 64'd0;
    rec_op        = 8'd0;
    rec_key_len   = 32'd0;
    rec_val_len   = 32'd0;
    rec_halted    = 1'b0;
    restart_record();
  endfunction

  function logic [3:0] record_verdict();
    if ((body_crc ^ CRC_PRESET) != rec_crc_field) return ST_CRC;
    if (rec_op != set_code && rec_op != delete_code) return ST_BAD_OP;
    if (rec_key_len == 32'd0) return ST_EMPTY_KEY;
    if (rec_op == set_code && rec_val_len == 32'd0) return ST_SET_EMPTY;
    return ST_OK;
  endfunction

  // Advances the parser by one input word and returns the result word it gives.
  function out_word_t deframe_byte(in_word_t w);
    out_word_t  r;
    logic [7:0] b;
    r           = '0;
    r.byte_kind = KIND_NONE;
    r.status    = ST_BUSY;
    b           = w.data_byte;
    if (w.end_of_input) begin
      restart_record();
      rec_halted = 1'b0;
      r.status   = ST_END;
    end else if (rec_halted) begin
      r.status = ST_HALTED;
    end else begin
      r.byte_out = b;
      if (rec_phase != AT_CRC) body_crc = crc32_next(body_crc, b);
      case (rec_phase)
        AT_HEADER: begin
          r.byte_kind = KIND_HDR;
          if (rec_count < TERM_END) rec_term = {rec_term[55:0], b};
          else if (rec_count < INDEX_END) rec_index = {rec_index[55:0], b};
          else if (rec_count == OP_POS) rec_op = b;
          else rec_key_len = {rec_key_len[23:0], b};
          rec_count++;
          if (rec_count >= HDR_BYTES) begin
            rec_count = 32'd0;
            if (rec_key_len > len_limit) r.status = ST_KEY_LEN;
            else if (rec_key_len != 32'd0) rec_phase = AT_KEY;
            else rec_phase = AT_VALUE_LEN;
          end
        end
        AT_KEY: begin
          r.byte_kind = KIND_KEY;
          rec_count++;
          if (rec_count >= rec_key_len) begin
            rec_count = 32'd0;
            rec_phase = AT_VALUE_LEN;
          end
        end
        AT_VALUE_LEN: begin
          r.byte_kind = KIND_VLEN;
          rec_val_len = {rec_val_len[23:0], b};
          rec_count++;
          if (rec_count >= VLEN_BYTES) begin
            rec_count = 32'd0;
            if (rec_val_len > len_limit) r.status = ST_VAL_LEN;
            else if (rec_val_len == 32'd0) r.status = record_verdict();
            else rec_phase = AT_VALUE;
          end
        end
        AT_VALUE: begin
          r.byte_kind = KIND_VAL;
          rec_count++;
          if (rec_count >= rec_val_len) begin
            rec_count = 32'd0;
            r.status  = record_verdict();
          end
        end
        default: begin
          r.byte_kind   = KIND_CRC;
          rec_crc_field = {rec_crc_field[23:0], b};
          rec_count++;
          if (rec_count >= CRC_BYTES) begin
            rec_count = 32'd0;
            rec_phase = AT_HEADER;
          end
        end
      endcase
      if (r.status == ST_OK) begin
        restart_record();
      end else if (r.status != ST_BUSY) begin
        rec_halted = 1'b1;
        restart_record();
      end
    end
    r.record_done  = (r.status == ST_OK);
    r.term         = rec_term;
    r.log_index    = rec_index;
    r.op_code      = rec_op;
    r.key_length   = rec_key_len;
    r.value_length = rec_val_len;
    return r;
  endfunction

  // Sender: called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_word(logic [7:0] b, logic eoi);
    in_word_t w;
    w.data_byte    = b;
    w.end_of_input = eoi;
    if (gaps_on && burst_left == 0) begin
      burst_left    = $urandom_range(1, 20);
      byte_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    byte_ch.valid = 1'b1;
    byte_ch.data  = w;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    expected_results.insert(expected_results.size(), deframe_byte(w));
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the sender until every outstanding result word is back.
  task automatic settle();
    byte_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MAX_LEN:   len_limit = value;
      CFG_SET_OP:    set_code = value[7:0];
      CFG_DELETE_OP: delete_code = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(logic [31:0] lim, logic [7:0] s, logic [7:0] d);
    write_reg(CFG_MAX_LEN, lim);
    write_reg(CFG_SET_OP, {24'd0, s});
    write_reg(CFG_DELETE_OP, {24'd0, d});
  endtask

  task automatic set_traffic(bit gaps, bit stalls);
    gaps_on       = gaps;
    stalls_on     = stalls;
    ready_pattern = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
    burst_left    = 0;
  endtask

  function automatic void add_frame_byte(logic [7:0] v);
    frame_bytes = {frame_bytes, v};
  endfunction

  function automatic void append_be(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) add_frame_byte(v[8*i +: 8]);
  endfunction

  // Frames one record and streams it. Key and value bodies longer than
  // FIELD_CAP are cut there and the stream is closed with end of input.
  task automatic send_record(logic [63:0] term_v, logic [63:0] index_v, logic [7:0] op_v,
                             logic [31:0] klen, logic [31:0] vlen, bit bad_crc, int cut_at);
    logic [31:0] crc;
    bit          cut_short;
    frame_bytes.delete();
    append_be(term_v, 8);
    append_be(index_v, 8);
    append_be({56'd0, op_v}, 1);
    append_be({32'd0, klen}, 4);
    for (int i = 0; i < FIELD_CAP && i < klen; i++) add_frame_byte(8'($urandom_range(0, 255)));
    if (klen <= FIELD_CAP) begin
      append_be({32'd0, vlen}, 4);
      for (int i = 0; i < FIELD_CAP && i < vlen; i++) add_frame_byte(8'($urandom_range(0, 255)));
    end
    crc = CRC_PRESET;
    foreach (frame_bytes[i]) crc = crc32_next(crc, frame_bytes[i]);
    crc = crc ^ CRC_PRESET;
    if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) frame_bytes.push_front(crc[8*i +: 8]);
    cut_short = (klen > FIELD_CAP) || (vlen > FIELD_CAP);
    foreach (frame_bytes[i]) begin
      if (cut_at != 0 && i == cut_at) begin
        cut_short = 1'b1;
        break;
      end
      send_word(frame_bytes[i], 1'b0);
    end
    if (rec_halted) repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
    if (cut_short || rec_halted) send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [31:0] pick_length(int zero_weight);
    int r;
    r = $urandom_range(0, 19);
    if (r < zero_weight) return 32'd0;
    if (r == 16) return (len_limit == 32'hFFFF_FFFF) ? len_limit : len_limit + 32'd1;
    if (r == 17) return len_limit;
    if (r == 18) return $urandom;
    return $urandom_range(1, 6);
  endfunction

  task automatic random_record();
    logic [7:0]  op;
    logic [63:0] t;
    logic [63:0] x;
    int          r;
    r  = $urandom_range(0, 9);
    op = (r < 4) ? set_code : (r < 8) ? delete_code : 8'($urandom_range(0, 255));
    t  = {$urandom, $urandom};
    x  = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) t = '1;
    if ($urandom_range(0, 9) == 0) x = '0;
    send_record(t, x, op, pick_length(2), pick_length(3), $urandom_range(0, 9) == 0,
                ($urandom_range(0, 11) == 0) ? $urandom_range(1, 30) : 0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 40)) send_word(8'($urandom_range(0, 255)), 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_default_registers();
    set_traffic(1'b0, 1'b0);
    send_record(64'h0123_4567_89AB_CDEF, 64'd1, SET_OP_RESET, 32'd3, 32'd2, 1'b0, 0);
    send_record('1, '0, DELETE_OP_RESET, 32'd2, 32'd0, 1'b0, 0);
    // A bad CRC outranks the op and empty key checks.
    send_record(64'd5, 64'd6, 8'd7, 32'd0, 32'd0, 1'b1, 0);
    send_record(64'd7, 64'd8, 8'd7, 32'd0, 32'd0, 1'b0, 0);
    send_record(64'd9, 64'd10, DELETE_OP_RESET, 32'd0, 32'd1, 1'b0, 0);
    send_record(64'd11, 64'd12, SET_OP_RESET, 32'd4, 32'd0, 1'b0, 0);
    send_record(64'd13, 64'd14, SET_OP_RESET, MAX_LEN_RESET + 32'd1, 32'd2, 1'b0, 0);
    send_record(64'd15, 64'd16, SET_OP_RESET, MAX_LEN_RESET, 32'd1, 1'b0, 0);
    // The value length is judged before the CRC.
    send_record(64'd17, 64'd18, SET_OP_RESET, 32'd2, MAX_LEN_RESET + 32'd1, 1'b1, 0);
    send_record(64'd19, 64'd20, DELETE_OP_RESET, 32'd3, 32'd3, 1'b0, 10);
    send_word(8'hA5, 1'b1);
    settle();
  endtask

  task automatic test_wide_limits();
    set_registers(32'hFFFF_FFFF, 8'hFF, 8'h00);
    set_traffic(1'b1, 1'b1);
    send_record(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE, 8'hFF, 32'd5, 32'd3, 1'b0, 0);
    send_record(64'd21, 64'd22, 8'h00, 32'd1, 32'd0, 1'b0, 0);
    send_record(64'd23, 64'd24, 8'hFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 0);
    send_record(64'd25, 64'd26, 8'h00, 32'd3, 32'hFFFF_FFFF, 1'b0, 0);
    settle();
  endtask

  task automatic test_zero_limit_shared_op();
    set_registers(32'd0, 8'h5A, 8'h5A);
    write_reg(CFG_SPARE, '1);
    set_traffic(1'b1, 1'b0);
    send_record(64'd27, 64'd28, 8'h5A, 32'd0, 32'd0, 1'b0, 0);
    send_record(64'd29, 64'd30, 8'h5A, 32'd1, 32'd0, 1'b0, 0);
    settle();
    write_reg(CFG_MAX_LEN, 32'd10);
    // With one code for both ops the record counts as a set.
    send_record(64'd31, 64'd32, 8'h5A, 32'd2, 32'd0, 1'b0, 0);
    send_record(64'd33, 64'd34, 8'h5A, 32'd2, 32'd3, 1'b0, 0);
    send_record(64'd35, 64'd36, 8'h5A, 32'd10, 32'd10, 1'b0, 0);
    send_record(64'd37, 64'd38, 8'h5A, 32'd10, 32'd11, 1'b0, 0);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [31:0] lim;
    logic [7:0]  s;
    int          r;
    int          phase_start;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        set_registers(MAX_LEN_RESET, 8'h00, 8'hFF);
      end else begin
        r = $urandom_range(0, 3);
        lim = (r == 0) ? 32'($urandom_range(2, 12)) : (r == 1) ? 32'hFFFF_FFFF :
              (r == 2) ? MAX_LEN_RESET : 32'($urandom_range(0, 3));
        s = 8'($urandom_range(0, 255));
        set_registers(lim, s, ($urandom_range(0, 4) == 0) ? s : 8'($urandom_range(0, 255)));
      end
      set_traffic(p % 3 != 1, p % 3 != 2);
      phase_start = words_sent;
      while (words_sent - phase_start < RANDOM_WORDS / RANDOM_PHASES) begin
        r = $urandom_range(0, 49);
        if (r == 0) settle();
        else if (r < 5) send_noise();
        else if (r < 7) send_word(8'($urandom_range(0, 255)), 1'b1);
        else random_record();
      end
      settle();
    end
  endtask

  // Receiver stalls follow a 16-bit ready pattern chosen per phase.
  always @(negedge clk) begin
    ready_step      = ready_step + 4'd1;
    result_ch.ready = stalls_on ? ready_pattern[ready_step] : 1'b1;
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    out_word_t got;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      got = result_ch.data;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result word: expected none actual %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("byte_kind", 64'(want.byte_kind), 64'(got.byte_kind));
        check_field("byte_out", 64'(want.byte_out), 64'(got.byte_out));
        check_field("record_done", 64'(want.record_done), 64'(got.record_done));
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("term", want.term, got.term);
        check_field("log_index", want.log_index, got.log_index);
        check_field("op_code", 64'(want.op_code), 64'(got.op_code));
        check_field("key_length", 64'(want.key_length), 64'(got.key_length));
        check_field("value_length", 64'(want.value_length), 64'(got.value_length));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MAX_LEN;
    cfg_data        = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.data    = '0;
    result_ch.ready = 1'b0;
    reset_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_registers();
    test_wide_limits();
    test_zero_limit_shared_op();
    test_random_traffic();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
